@@ rtl/stkit_pkg.sv @@
// ----------------------------------------------------------------------------
// stkit_pkg
// Shared constants, codes and control types of the sorted three-key table.
// ----------------------------------------------------------------------------
package stkit_pkg;

  // default sizes
  localparam int DEPTH_DEF    = 64;
  localparam int KEY_BITS_DEF = 16;

  // fixed field widths of the channels
  localparam int FIELD_W = 16;
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 6;
  localparam int POS_W   = 7;
  localparam int ST_W    = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // read address source
  typedef enum logic [1:0] {
    RD_PRIME = 2'd0,  // last valid entry
    RD_SHIFT = 2'd1,  // entry below the current one
    RD_IDX   = 2'd2   // requested index
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic            latch;
    logic            clr_cnt;
    logic            set_st;
    logic [ST_W-1:0] st_code;
    logic            rd_en;
    rd_sel_t         rd_sel;
    logic            wr_shift;
    logic            wr_new_hi;
    logic            wr_new_lo;
    logic            cap_read;
    logic            load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             full;
    logic             idx_ok;
    logic             cnt_zero;
    logic             gt;
    logic             cur_zero;
  } dp_sts_t;

endpackage

@@ rtl/stkit_req_if.sv @@
// ----------------------------------------------------------------------------
// stkit_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface stkit_req_if;
  logic                           valid;
  logic                           ready;
  logic [stkit_pkg::REQ_W-1:0]    req_type;
  logic [stkit_pkg::FIELD_W-1:0]  new_speed;
  logic [stkit_pkg::FIELD_W-1:0]  new_accel;
  logic [stkit_pkg::FIELD_W-1:0]  new_range;
  logic [stkit_pkg::FIELD_W-1:0]  new_tag;
  logic [stkit_pkg::IDX_W-1:0]    read_index;

  modport source (
    output valid, req_type, new_speed, new_accel, new_range, new_tag, read_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, new_speed, new_accel, new_range, new_tag, read_index,
    output ready
  );
endinterface

@@ rtl/stkit_rsp_if.sv @@
// ----------------------------------------------------------------------------
// stkit_rsp_if
// Response channel: valid/ready handshake with the response payload.
// ----------------------------------------------------------------------------
interface stkit_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [stkit_pkg::ST_W-1:0]     status;
  logic [stkit_pkg::POS_W-1:0]    insert_position;
  logic [stkit_pkg::POS_W-1:0]    entry_count;
  logic [stkit_pkg::FIELD_W-1:0]  out_speed;
  logic [stkit_pkg::FIELD_W-1:0]  out_accel;
  logic [stkit_pkg::FIELD_W-1:0]  out_range;
  logic [stkit_pkg::FIELD_W-1:0]  out_tag;

  modport source (
    output valid, status, insert_position, entry_count,
           out_speed, out_accel, out_range, out_tag,
    input  ready
  );
  modport sink (
    input  valid, status, insert_position, entry_count,
           out_speed, out_accel, out_range, out_tag,
    output ready
  );
endinterface

@@ rtl/sorted_three_key_insert_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_three_key_insert_table_core
// Ordered table of entries kept ascending by speed, accel, range, with a tag.
// ----------------------------------------------------------------------------
// One request is handled at a time and answers with exactly one response
// transaction. An insert walks the table from its top entry downward through
// the entry RAM, moving each greater entry up one slot per cycle over the
// RAM's single write port; equal keys keep arrival order. A read passes
// through an address state and a capture state; a clear, a refused insert or
// an out-of-range read goes straight to the response state. A new
// request is taken as soon as the previous response sits in the output
// register, even while that response waits to be taken. No clearing pass is
// needed after reset: only entries below the count are ever read.
module sorted_three_key_insert_table_core #(
  parameter int DEPTH    = stkit_pkg::DEPTH_DEF,
  parameter int KEY_BITS = stkit_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  stkit_req_if.sink   in_req,
  stkit_rsp_if.source out_rsp
);

  stkit_pkg::dp_cmd_t cmd;
  stkit_pkg::dp_sts_t sts;

  // sequencing and handshakes
  stkit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, compare and response registers
  stkit_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req.req_type),
    .in_new_speed        (in_req.new_speed),
    .in_new_accel        (in_req.new_accel),
    .in_new_range        (in_req.new_range),
    .in_new_tag          (in_req.new_tag),
    .in_read_index       (in_req.read_index),
    .out_status          (out_rsp.status),
    .out_insert_position (out_rsp.insert_position),
    .out_entry_count     (out_rsp.entry_count),
    .out_speed           (out_rsp.out_speed),
    .out_accel           (out_rsp.out_accel),
    .out_range           (out_rsp.out_range),
    .out_tag             (out_rsp.out_tag)
  );

endmodule

@@ rtl/stkit_ram.sv @@
// ----------------------------------------------------------------------------
// stkit_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module stkit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/stkit_dp.sv @@
// ----------------------------------------------------------------------------
// stkit_dp
// Datapath: entry RAM, count, scan pointer, key compare and response registers.
// ----------------------------------------------------------------------------
module stkit_dp #(
  parameter int DEPTH    = stkit_pkg::DEPTH_DEF,
  parameter int KEY_BITS = stkit_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stkit_pkg::dp_cmd_t             cmd,
  output stkit_pkg::dp_sts_t             sts,
  // request fields
  input  logic [stkit_pkg::REQ_W-1:0]    in_req_type,
  input  logic [stkit_pkg::FIELD_W-1:0]  in_new_speed,
  input  logic [stkit_pkg::FIELD_W-1:0]  in_new_accel,
  input  logic [stkit_pkg::FIELD_W-1:0]  in_new_range,
  input  logic [stkit_pkg::FIELD_W-1:0]  in_new_tag,
  input  logic [stkit_pkg::IDX_W-1:0]    in_read_index,
  // response fields
  output logic [stkit_pkg::ST_W-1:0]     out_status,
  output logic [stkit_pkg::POS_W-1:0]    out_insert_position,
  output logic [stkit_pkg::POS_W-1:0]    out_entry_count,
  output logic [stkit_pkg::FIELD_W-1:0]  out_speed,
  output logic [stkit_pkg::FIELD_W-1:0]  out_accel,
  output logic [stkit_pkg::FIELD_W-1:0]  out_range,
  output logic [stkit_pkg::FIELD_W-1:0]  out_tag
);

  localparam int FW = stkit_pkg::FIELD_W;
  localparam int KW = (KEY_BITS < FW) ? KEY_BITS : FW;
  localparam int EW = 3 * KW + FW;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > stkit_pkg::IDX_W) ? CW : stkit_pkg::IDX_W;
  localparam int XW = (CW > stkit_pkg::POS_W) ? CW : stkit_pkg::POS_W;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] idx_r;
  logic [EW-1:0] new_ent_r;
  logic [stkit_pkg::ST_W-1:0] res_st_r, res_st_nxt;
  logic [AW-1:0] res_pos_r;
  logic [EW-1:0] res_ent_r;

  logic [stkit_pkg::ST_W-1:0]  out_st_r;
  logic [stkit_pkg::POS_W-1:0] out_pos_r;
  logic [stkit_pkg::POS_W-1:0] out_cnt_r;
  logic [EW-1:0]               out_ent_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;
  logic [EW-1:0] rd_data;
  logic [AW-1:0] cur_up;
  logic [IW-1:0] idx_ext;
  logic [XW-1:0] pos_ext;
  logic [XW-1:0] cnt_ext;

  // entry storage
  stkit_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // status toward the controller
  assign idx_ext      = IW'(in_read_index);
  assign sts.req      = in_req_type;
  assign sts.full     = (cnt_r == CW'(DEPTH));
  assign sts.idx_ok   = (idx_ext < IW'(cnt_r));
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cur_zero = (cur_r == '0);
  // keys packed speed, accel, range: one unsigned compare is lexicographic
  assign sts.gt       = (rd_data[EW-1:FW] > new_ent_r[EW-1:FW]);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      stkit_pkg::RD_PRIME: rd_addr = AW'(cnt_r - CW'(1));
      stkit_pkg::RD_SHIFT: rd_addr = cur_r - AW'(1);
      stkit_pkg::RD_IDX:   rd_addr = idx_r;
      default:             rd_addr = idx_r;
    endcase
  end

  // write port: shift one up or place the new entry
  assign cur_up  = cur_r + AW'(1);
  assign wr_en   = cmd.wr_shift | cmd.wr_new_hi | cmd.wr_new_lo;
  assign wr_addr = cmd.wr_new_lo ? '0 : cur_up;
  assign wr_data = cmd.wr_shift ? rd_data : new_ent_r;

  // scan pointer follows the read address issued by the prime and shift reads
  always_comb begin
    cur_nxt = cur_r;
    if (cmd.rd_en && (cmd.rd_sel inside {stkit_pkg::RD_PRIME, stkit_pkg::RD_SHIFT})) begin
      cur_nxt = rd_addr;
    end
  end

  // entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr_cnt) begin
      cnt_nxt = '0;
    end else if (cmd.wr_new_hi || cmd.wr_new_lo) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // result status
  always_comb begin
    res_st_nxt = res_st_r;
    if (cmd.set_st) begin
      res_st_nxt = cmd.st_code;
    end else if (cmd.latch) begin
      res_st_nxt = stkit_pkg::ST_OK;
    end
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    res_st_r <= res_st_nxt;
    if (cmd.latch) begin
      new_ent_r <= {in_new_speed[KW-1:0], in_new_accel[KW-1:0],
                    in_new_range[KW-1:0], in_new_tag};
      idx_r     <= idx_ext[AW-1:0];
      res_pos_r <= '0;
      res_ent_r <= '0;
    end else begin
      if (cmd.wr_new_hi) begin
        res_pos_r <= cur_up;
      end
      if (cmd.cap_read) begin
        res_ent_r <= rd_data;
      end
    end
  end

  // response register
  assign pos_ext = XW'(res_pos_r);
  assign cnt_ext = XW'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_st_r  <= res_st_r;
      out_pos_r <= pos_ext[stkit_pkg::POS_W-1:0];
      out_cnt_r <= cnt_ext[stkit_pkg::POS_W-1:0];
      out_ent_r <= res_ent_r;
    end
  end

  assign out_status          = out_st_r;
  assign out_insert_position = out_pos_r;
  assign out_entry_count     = out_cnt_r;
  assign out_speed           = FW'(out_ent_r[EW-1:FW+2*KW]);
  assign out_accel           = FW'(out_ent_r[FW+2*KW-1:FW+KW]);
  assign out_range           = FW'(out_ent_r[FW+KW-1:FW]);
  assign out_tag             = out_ent_r[FW-1:0];

endmodule

@@ rtl/stkit_ctrl.sv @@
// ----------------------------------------------------------------------------
// stkit_ctrl
// Controller: sequences insert scan, indexed read and clear; owns handshakes.
// ----------------------------------------------------------------------------
module stkit_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  stkit_pkg::dp_sts_t  sts,
  output stkit_pkg::dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PRIME = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_PLACE = 7'b0001000,
    S_RDADR = 7'b0010000,
    S_RDCAP = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.rd_sel    = stkit_pkg::RD_IDX;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (sts.req)
            stkit_pkg::REQ_INSERT: begin
              if (sts.full) begin
                cmd.set_st  = 1'b1;
                cmd.st_code = stkit_pkg::ST_FULL;
                state_nxt   = S_RESP;
              end else if (sts.cnt_zero) begin
                state_nxt = S_PLACE;
              end else begin
                state_nxt = S_PRIME;
              end
            end
            stkit_pkg::REQ_READ: begin
              if (sts.idx_ok) begin
                state_nxt = S_RDADR;
              end else begin
                cmd.set_st  = 1'b1;
                cmd.st_code = stkit_pkg::ST_RANGE;
                state_nxt   = S_RESP;
              end
            end
            stkit_pkg::REQ_CLEAR: begin
              cmd.clr_cnt = 1'b1;
              state_nxt   = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      // fetch the last valid entry
      S_PRIME: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = stkit_pkg::RD_PRIME;
        state_nxt  = S_SHIFT;
      end
      // walk down: move greater entries up, drop new entry above the first not greater
      S_SHIFT: begin
        if (sts.gt) begin
          cmd.wr_shift = 1'b1;
          if (sts.cur_zero) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = stkit_pkg::RD_SHIFT;
          end
        end else begin
          cmd.wr_new_hi = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      // new entry goes to the bottom
      S_PLACE: begin
        cmd.wr_new_lo = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RDADR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = stkit_pkg::RD_IDX;
        state_nxt  = S_RDCAP;
      end
      S_RDCAP: begin
        cmd.cap_read = 1'b1;
        state_nxt    = S_RESP;
      end
      // hand the result to the response register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ verif/tb_sorted_three_key_insert_table_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_three_key_insert_table_core
// Self-checking bench for the sorted three-key insert table.
// ----------------------------------------------------------------------------
// A queue of requests is built up front. It starts with hand-picked cases:
// key extremes, ties on each key level, equal keys, reads past the count,
// unknown requests and clears. After that come random fill runs, read sweeps
// and noise. A clocked driver feeds the queue with random gaps. Each accepted
// transaction runs through a local shadow of the table, and the predicted
// response is stored. A clocked process applies random back-pressure and a
// monitor checks every response field against the oldest stored prediction.
// ----------------------------------------------------------------------------
module tb_sorted_three_key_insert_table_core;

  localparam int FW           = stkit_pkg::FIELD_W;
  localparam int RW           = stkit_pkg::REQ_W;
  localparam int IW           = stkit_pkg::IDX_W;
  localparam int PW           = stkit_pkg::POS_W;
  localparam int SW           = stkit_pkg::ST_W;
  localparam int TBL_DEPTH    = stkit_pkg::DEPTH_DEF;
  localparam int DRAIN_CYCLES = stkit_pkg::DEPTH_DEF + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [RW-1:0] REQ_NOP = 2'd3;

  typedef struct {
    logic [RW-1:0] req_type;
    logic [FW-1:0] speed;
    logic [FW-1:0] accel;
    logic [FW-1:0] rng;
    logic [FW-1:0] tag;
    logic [IW-1:0] index;
  } table_req_t;

  typedef struct {
    logic [SW-1:0] status;
    logic [PW-1:0] position;
    logic [PW-1:0] count;
    logic [FW-1:0] speed;
    logic [FW-1:0] accel;
    logic [FW-1:0] rng;
    logic [FW-1:0] tag;
  } table_rsp_t;

  typedef struct {
    logic [FW-1:0] speed;
    logic [FW-1:0] accel;
    logic [FW-1:0] rng;
    logic [FW-1:0] tag;
  } slot_t;

  logic clk;
  logic rst_n;

  stkit_req_if req_ch ();
  stkit_rsp_if rsp_ch ();

  sorted_three_key_insert_table_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  table_req_t pending_reqs[$];
  table_rsp_t expected_rsps[$];
  slot_t      shadow_slots[TBL_DEPTH];
  int         shadow_count;
  int         gen_count;
  int         made_count;
  int         fail_count;
  int         cycle_count;

  table_req_t on_wire;
  table_rsp_t got_rsp;
  table_rsp_t want_rsp;
  int         send_gap;
  bit         send_calm;
  int         stall_left;
  bit         rsp_calm;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // true when slot a sorts strictly after slot b
  function automatic bit slot_after(slot_t a, slot_t b);
    if (a.speed != b.speed) return a.speed > b.speed;
    if (a.accel != b.accel) return a.accel > b.accel;
    return a.rng > b.rng;
  endfunction

  // shadow table: apply one request, return the response it should produce
  function automatic table_rsp_t apply_request(table_req_t r);
    table_rsp_t res;
    slot_t      fresh;
    int         pos;
    int         j;
    res = '{default: '0};
    fresh = '{r.speed, r.accel, r.rng, r.tag};
    pos = 0;
    case (r.req_type)
      stkit_pkg::REQ_INSERT: begin
        if (shadow_count >= TBL_DEPTH) begin
          res.status = stkit_pkg::ST_FULL;
        end else begin
          while (pos < shadow_count && !slot_after(shadow_slots[pos], fresh)) pos++;
          for (j = shadow_count; j > pos; j--) shadow_slots[j] = shadow_slots[j-1];
          shadow_slots[pos] = fresh;
          shadow_count++;
          res.position = pos[PW-1:0];
        end
      end
      stkit_pkg::REQ_READ: begin
        if (int'(r.index) >= shadow_count) begin
          res.status = stkit_pkg::ST_RANGE;
        end else begin
          res.speed = shadow_slots[r.index].speed;
          res.accel = shadow_slots[r.index].accel;
          res.rng   = shadow_slots[r.index].rng;
          res.tag   = shadow_slots[r.index].tag;
        end
      end
      stkit_pkg::REQ_CLEAR: begin
        shadow_count = 0;
      end
      default: ;
    endcase
    res.count = shadow_count[PW-1:0];
    return res;
  endfunction

  // all fields random, request type chosen by the caller
  function automatic table_req_t junk_req(logic [RW-1:0] kind);
    table_req_t r;
    r.req_type = kind;
    r.speed    = FW'($urandom_range(0, 65535));
    r.accel    = FW'($urandom_range(0, 65535));
    r.rng      = FW'($urandom_range(0, 65535));
    r.tag      = FW'($urandom_range(0, 65535));
    r.index    = IW'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic table_req_t make_req(logic [RW-1:0] kind, int s, int a, int rg,
                                          int t, int idx);
    table_req_t r;
    r.req_type = kind;
    r.speed    = s[FW-1:0];
    r.accel    = a[FW-1:0];
    r.rng      = rg[FW-1:0];
    r.tag      = t[FW-1:0];
    r.index    = idx[IW-1:0];
    return r;
  endfunction

  // key values: 0 wide, 1 narrow (lots of ties), 2 near the extremes
  function automatic logic [FW-1:0] pick_key(int style);
    case (style)
      1: return FW'($urandom_range(0, 3));
      2: return ($urandom_range(0, 1) != 0) ? FW'(65535 - $urandom_range(0, 1))
                                            : FW'($urandom_range(0, 1));
      default: return FW'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly valid positions, some at or past the count
  function automatic logic [IW-1:0] pick_index();
    if (gen_count >= TBL_DEPTH || (gen_count > 0 && $urandom_range(0, 99) < 85))
      return IW'($urandom_range(0, gen_count - 1));
    return IW'($urandom_range(gen_count, 63));
  endfunction

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(1, 2);
    if (roll < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  task automatic queue_item(table_req_t r);
    pending_reqs.push_back(r);
    if (r.req_type == stkit_pkg::REQ_INSERT && gen_count < TBL_DEPTH) gen_count++;
    if (r.req_type == stkit_pkg::REQ_CLEAR) gen_count = 0;
    if (r.req_type != REQ_NOP) made_count++;
  endtask

  // directed cases: extremes, tie-breaks on every key, equal keys, misses
  task automatic build_directed();
    int i;
    queue_item(make_req(stkit_pkg::REQ_READ, 0, 0, 0, 0, 0));
    queue_item(make_req(REQ_NOP, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 63));
    queue_item(make_req(stkit_pkg::REQ_CLEAR, 'hFFFF, 0, 'hFFFF, 0, 63));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 0, 0, 0, 0, 0));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 63));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 5, 5, 5, 1, 0));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 5, 5, 5, 2, 0));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 5, 5, 4, 3, 0));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 5, 4, 'hFFFF, 4, 0));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 5, 6, 0, 5, 0));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 0, 0, 0, 6, 0));
    queue_item(make_req(stkit_pkg::REQ_INSERT, 'hFFFF, 'hFFFF, 'hFFFF, 7, 0));
    for (i = 0; i < 9; i++) queue_item(make_req(stkit_pkg::REQ_READ, 0, 0, 0, 0, i));
    queue_item(make_req(stkit_pkg::REQ_READ, 0, 0, 0, 0, 9));
    queue_item(make_req(stkit_pkg::REQ_READ, 0, 0, 0, 0, 63));
    queue_item(make_req(stkit_pkg::REQ_CLEAR, 0, 0, 0, 0, 0));
    queue_item(make_req(stkit_pkg::REQ_READ, 0, 0, 0, 0, 0));
  endtask

  // random part: fill runs up to and past full, read sweeps, noise
  task automatic build_random();
    int         roll;
    int         style;
    int         n;
    table_req_t r;
    made_count = 0;
    while (made_count < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        if ($urandom_range(0, 2) != 0) queue_item(junk_req(stkit_pkg::REQ_CLEAR));
        style = $urandom_range(0, 2);
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40) : $urandom_range(60, 72);
        repeat (n) begin
          r = junk_req(stkit_pkg::REQ_INSERT);
          r.speed = pick_key(style);
          r.accel = pick_key(style);
          r.rng   = pick_key(style);
          queue_item(r);
          if ($urandom_range(0, 3) == 0) begin
            r = junk_req(stkit_pkg::REQ_READ);
            r.index = pick_index();
            queue_item(r);
          end
        end
      end else if (roll < 80) begin
        repeat ($urandom_range(4, 20)) begin
          r = junk_req(stkit_pkg::REQ_READ);
          r.index = pick_index();
          queue_item(r);
        end
      end else begin
        repeat ($urandom_range(2, 10)) queue_item(junk_req(RW'($urandom_range(0, 3))));
      end
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
      send_calm = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) expected_rsps.push_back(apply_request(on_wire));
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          on_wire = pending_reqs.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= on_wire.req_type;
          req_ch.new_speed  <= on_wire.speed;
          req_ch.new_accel  <= on_wire.accel;
          req_ch.new_range  <= on_wire.rng;
          req_ch.new_tag    <= on_wire.tag;
          req_ch.read_index <= on_wire.index;
          if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
          send_gap = (send_calm || $urandom_range(0, 1) != 0) ? 0 : pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      rsp_calm = 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) rsp_calm = !rsp_calm;
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!rsp_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got_rsp = '{rsp_ch.status, rsp_ch.insert_position, rsp_ch.entry_count,
                  rsp_ch.out_speed, rsp_ch.out_accel, rsp_ch.out_range, rsp_ch.out_tag};
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response, expected none, got status %0d count %0d",
                 $time, got_rsp.status, got_rsp.count);
        fail_count++;
      end else begin
        want_rsp = expected_rsps.pop_front();
        check_field("status", int'(want_rsp.status), int'(got_rsp.status));
        check_field("insert_position", int'(want_rsp.position), int'(got_rsp.position));
        check_field("entry_count", int'(want_rsp.count), int'(got_rsp.count));
        check_field("out_speed", int'(want_rsp.speed), int'(got_rsp.speed));
        check_field("out_accel", int'(want_rsp.accel), int'(got_rsp.accel));
        check_field("out_range", int'(want_rsp.rng), int'(got_rsp.rng));
        check_field("out_tag", int'(want_rsp.tag), int'(got_rsp.tag));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_three_key_insert_table_core verification failed");
      $finish;
    end
  end

  // reset, stimulus and end of run
  initial begin
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_NOP;
    req_ch.new_speed  = '0;
    req_ch.new_accel  = '0;
    req_ch.new_range  = '0;
    req_ch.new_tag    = '0;
    req_ch.read_index = '0;
    rsp_ch.ready      = 1'b0;
    shadow_count      = 0;
    gen_count         = 0;
    fail_count        = 0;
    cycle_count       = 0;
    build_directed();
    build_random();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_reqs.size() > 0 || req_ch.valid) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("sorted_three_key_insert_table_core verification clean");
    end else begin
      $display("sorted_three_key_insert_table_core verification failed");
    end
    $finish;
  end

endmodule

@@ sorted_three_key_insert_table_core.f @@
rtl/stkit_pkg.sv
rtl/stkit_req_if.sv
rtl/stkit_rsp_if.sv
rtl/stkit_ram.sv
rtl/stkit_dp.sv
rtl/stkit_ctrl.sv
rtl/sorted_three_key_insert_table_core.sv
verif/tb_sorted_three_key_insert_table_core.sv
